@@ rtl/stc_pkg.sv @@
// Shared types and codes for the sorted table engine.
// No dependencies; every other file in rtl/ imports this package.
package stc_pkg;

    localparam int unsigned DEPTH_DEF       = 16;
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    localparam int unsigned ACTION_W    = 2;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned INDEX_W     = 4;
    localparam int unsigned OCCUPANCY_W = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEL_POS = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_DEL_KEY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // Command broadcast to every cell in the update cycle
    typedef struct packed {
        logic                commit;
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    pos;
    } cell_cmd_t;

endpackage

@@ rtl/stc_cell.sv @@
// One slot of the sorted table: holds an entry, compares it to the key, shifts.
// Depends on stc_pkg.
module stc_cell
    import stc_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int unsigned IDX         = 0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample,
    input  logic                          occupied,
    input  logic signed [VALUE_WIDTH-1:0] cmp_key,
    input  logic signed [VALUE_WIDTH-1:0] load_key,
    input  cell_cmd_t                     cmd,
    input  logic                          lt_left,
    input  logic signed [VALUE_WIDTH-1:0] left_data,
    input  logic signed [VALUE_WIDTH-1:0] right_data,
    output logic signed [VALUE_WIDTH-1:0] data,
    output logic                          lt,
    output logic                          edge_hit,
    output logic                          eq_hit
);

    logic signed [VALUE_WIDTH-1:0] data_reg;
    logic signed [VALUE_WIDTH-1:0] data_next;
    logic                          lt_reg;
    logic                          eq_reg;
    logic                          at_edge;
    logic                          at_or_past_pos;

    // First slot that does not hold a smaller value
    assign at_edge        = !lt_reg && ((IDX == 0) || lt_left);
    assign at_or_past_pos = int'(IDX) >= int'(cmd.pos);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.commit)
        begin
            unique case (cmd.action)
                ACT_INSERT:
                begin
                    if (at_edge)
                    begin
                        data_next = load_key;
                    end
                    else if (!lt_reg)
                    begin
                        data_next = left_data;
                    end
                end
                ACT_DEL_POS:
                begin
                    if (at_or_past_pos)
                    begin
                        data_next = right_data;
                    end
                end
                ACT_DEL_KEY:
                begin
                    if (!lt_reg)
                    begin
                        data_next = right_data;
                    end
                end
                default:
                begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (sample)
        begin
            lt_reg <= occupied && (data_reg < cmp_key);
            eq_reg <= occupied && (data_reg == cmp_key);
        end
    end

    assign data     = data_reg;
    assign lt       = lt_reg;
    assign edge_hit = at_edge;
    assign eq_hit   = eq_reg;

endmodule

@@ rtl/stc_encoder.sv @@
// Turns the one-hot edge marker of the cell row into an index and a match flag.
// Depends on stc_pkg.
module stc_encoder
    import stc_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
)
(
    input  logic [DEPTH-1:0]         edge_hit,
    input  logic [DEPTH-1:0]         eq_hit,
    output logic [$clog2(DEPTH)-1:0] idx,
    output logic                     found
);

    localparam int unsigned IW = $clog2(DEPTH);

    always_comb
    begin
        idx   = '0;
        found = 1'b0;
        for (int i = 0; i < int'(DEPTH); i++)
        begin
            if (edge_hit[i])
            begin
                idx = idx | IW'(i);
            end
            found = found | (edge_hit[i] & eq_hit[i]);
        end
    end

endmodule

@@ rtl/sorted_table_engine.sv @@
// Sorted table engine: keeps up to DEPTH signed values in ascending order in a
// row of cells and serves insert, delete by position, search and delete by key.
// Depends on stc_pkg, stc_cell and stc_encoder.
//
// Each request beat gets exactly one result beat: status, index and occupancy
// after the request. In the cycle a request is accepted every cell compares
// its entry with the key and registers the flags; then, in the update cycle,
// the edge index is encoded, the status is decided and each cell keeps, loads
// the key, or takes its left or right neighbor's entry. A new request is not
// taken until the one in flight has been updated. The result sits in an output
// register, so the next request is taken while a result waits; the update
// cycle holds only while that register is still full and not being read.
// Equal values insert in front of existing equal ones; search and delete by
// key act on the first equal entry. Entries are not cleared at reset; the
// fill count is, and no slot at or beyond it ever affects a result.
module sorted_table_engine
    import stc_pkg::*;
#(
    parameter int unsigned DEPTH       = DEPTH_DEF,
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int unsigned IN_W        = ((ACTION_W + VALUE_WIDTH + POS_W + 7) / 8) * 8,
    parameter int unsigned OUT_W       = ((STATUS_W + INDEX_W + OCCUPANCY_W + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // action, value (VALUE_WIDTH bits), position; zero padding above
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status, index, occupancy; zero padding above
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic state_reg;
    logic state_next;

    logic [ACTION_W-1:0]           action_reg;
    logic [POS_W-1:0]              pos_reg;
    logic signed [VALUE_WIDTH-1:0] key_reg;

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [STATUS_W-1:0]      out_status_reg;
    logic [INDEX_W-1:0]       out_index_reg;
    logic [OCCUPANCY_W-1:0]   out_occ_reg;

    logic [ACTION_W-1:0]           in_action;
    logic signed [VALUE_WIDTH-1:0] in_value;
    logic [POS_W-1:0]              in_pos;

    logic accept;
    logic update;

    logic signed [VALUE_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]              cell_lt;
    logic [DEPTH-1:0]              cell_edge;
    logic [DEPTH-1:0]              cell_eq;
    logic [DEPTH-1:0]              cell_occ;

    logic [IW-1:0]       edge_idx;
    logic                key_found;
    logic [STATUS_W-1:0] status;
    logic [IW-1:0]       res_idx;
    logic                change;
    cell_cmd_t           cmd;

    logic [IW+INDEX_W-1:0]     idx_ext;
    logic [CW+OCCUPANCY_W-1:0] occ_ext;

    // Unpack the request beat
    assign in_action = s_axis_tdata[ACTION_W-1:0];
    assign in_value  = s_axis_tdata[ACTION_W +: VALUE_WIDTH];
    assign in_pos    = s_axis_tdata[ACTION_W + VALUE_WIDTH +: POS_W];

    // Take a request whenever no request is in flight
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    // Advance the in-flight request only when the result slot is free
    assign update        = (state_reg == ST_BUSY) && (!out_valid_reg || m_axis_tready);

    genvar g;
    generate
        for (g = 0; g < int'(DEPTH); g++)
        begin : g_cell
            logic signed [VALUE_WIDTH-1:0] left_d;
            logic signed [VALUE_WIDTH-1:0] right_d;
            logic                          left_lt;

            assign cell_occ[g] = int'(fill_reg) > g;

            if (g == 0)
            begin : g_first
                assign left_d  = cell_data[0];
                assign left_lt = 1'b0;
            end
            else
            begin : g_inner
                assign left_d  = cell_data[g-1];
                assign left_lt = cell_lt[g-1];
            end

            if (g == int'(DEPTH) - 1)
            begin : g_last
                assign right_d = cell_data[g];
            end
            else
            begin : g_mid
                assign right_d = cell_data[g+1];
            end

            stc_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .IDX         (g)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .sample     (accept),
                .occupied   (cell_occ[g]),
                .cmp_key    (in_value),
                .load_key   (key_reg),
                .cmd        (cmd),
                .lt_left    (left_lt),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[g]),
                .lt         (cell_lt[g]),
                .edge_hit   (cell_edge[g]),
                .eq_hit     (cell_eq[g])
            );
        end
    endgenerate

    stc_encoder #(
        .DEPTH (DEPTH)
    ) u_encoder (
        .edge_hit (cell_edge),
        .eq_hit   (cell_eq),
        .idx      (edge_idx),
        .found    (key_found)
    );

    // Decide status, result index and whether the table changes
    always_comb
    begin
        status  = ST_OK;
        res_idx = '0;
        change  = 1'b0;
        unique case (action_reg)
            ACT_INSERT:
            begin
                if (int'(fill_reg) >= int'(DEPTH))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    res_idx = edge_idx;
                    change  = 1'b1;
                end
            end
            ACT_DEL_POS:
            begin
                if (fill_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else if (int'(pos_reg) >= int'(fill_reg))
                begin
                    status = ST_BADPOS;
                end
                else
                begin
                    res_idx = IW'(int'(pos_reg));
                    change  = 1'b1;
                end
            end
            ACT_SEARCH, ACT_DEL_KEY:
            begin
                if (fill_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else if (!key_found)
                begin
                    status = ST_NOTFOUND;
                end
                else
                begin
                    res_idx = edge_idx;
                    change  = (action_reg == ACT_DEL_KEY);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign cmd.commit = update && change;
    assign cmd.action = action_reg;
    assign cmd.pos    = pos_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.commit)
        begin
            if (action_reg == ACT_INSERT)
            begin
                fill_next = fill_reg + 1'b1;
            end
            else
            begin
                fill_next = fill_reg - 1'b1;
            end
        end
    end

    assign idx_ext = {{INDEX_W{1'b0}}, res_idx};
    assign occ_ext = {{OCCUPANCY_W{1'b0}}, fill_next};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (update)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (update)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request operands for the update cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= in_action;
            pos_reg    <= in_pos;
            key_reg    <= in_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            out_status_reg <= status;
            out_index_reg  <= (status == ST_OK) ? idx_ext[INDEX_W-1:0] : '0;
            out_occ_reg    <= occ_ext[OCCUPANCY_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - STATUS_W - INDEX_W - OCCUPANCY_W){1'b0}},
                            out_occ_reg, out_index_reg, out_status_reg};

endmodule

@@ rtl/stc_checker.sv @@
// Port-level checks on the result stream of the sorted table engine.
// Depends on stc_pkg; bound to sorted_table_engine below.
module stc_checker
    import stc_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF,
    parameter int unsigned OUT_W = 16
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    localparam logic [OCCUPANCY_W-1:0] FULL_OCC = OCCUPANCY_W'(DEPTH);

    logic [STATUS_W-1:0]    r_status;
    logic [INDEX_W-1:0]     r_index;
    logic [OCCUPANCY_W-1:0] r_occ;

    assign r_status = m_axis_tdata[STATUS_W-1:0];
    assign r_index  = m_axis_tdata[STATUS_W +: INDEX_W];
    assign r_occ    = m_axis_tdata[STATUS_W + INDEX_W +: OCCUPANCY_W];

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (r_status == ST_OK || r_status == ST_EMPTY ||
                           r_status == ST_BADPOS || r_status == ST_NOTFOUND ||
                           r_status == ST_FULL))
        else $error("result status outside the defined codes");

    a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && r_status != ST_OK) |-> (r_index == '0))
        else $error("failed request reports a nonzero index");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && r_status == ST_EMPTY) |-> (r_occ == '0))
        else $error("empty status with nonzero occupancy");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && r_status == ST_FULL) |-> (r_occ == FULL_OCC))
        else $error("full status while table not full");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind sorted_table_engine stc_checker #(
    .DEPTH (DEPTH),
    .OUT_W (OUT_W)
) u_stc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/sorted_table_engine_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for sorted_table_engine: a directed table of requests, then
// about 1100 random ones under four handshake pressure phases. Depends on stc_pkg.
module sorted_table_engine_tb;
    import stc_pkg::*;

    localparam int TABLE_DEPTH    = DEPTH_DEF;
    localparam int VAL_W          = VALUE_WIDTH_DEF;
    localparam int IN_BITS        = ((ACTION_W + VAL_W + POS_W + 7) / 8) * 8;
    localparam int OUT_BITS       = ((STATUS_W + INDEX_W + OCCUPANCY_W + 7) / 8) * 8;
    localparam int PAD_BITS       = IN_BITS - (ACTION_W + VAL_W + POS_W);
    localparam int RANDOM_PER_PHASE = 275;
    localparam int MIX_BLOCK      = 40;      // requests per fill/drain/churn stretch
    localparam int WATCHDOG_LIMIT = 5000;    // cycles with no beat on either side
    localparam int DRAIN_CYCLES   = 20;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]       position;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [INDEX_W-1:0]     index;
        logic [OCCUPANCY_W-1:0] occupancy;
    } result_t;

    typedef struct {
        request_t req;
        bit       typed;    // expected result written into the row
        result_t  exp;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata;   // action, value, position; zero padding above
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;   // status, index, occupancy; zero padding above

    // Side information that travels with the request beat; driven with the beat
    // so the monitor sees exactly what belongs to the accepted request.
    bit      beat_typed;
    result_t beat_exp;

    // Shadow of the block's contents, updated at each accepted request beat
    logic signed [VAL_W-1:0] sorted_vals [TABLE_DEPTH];
    int                      held_count;

    result_t  pending_results[$];
    dir_row_t dir_rows[$];

    int sender_idle_pct;
    int sink_stall_pct;
    int error_count;
    int requests_sent;
    int results_checked;
    int stall_cycles;
    int status_seen [5];

    sorted_table_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Close the gap left by a removal at the given slot
    function automatic void drop_entry(int at);
        int i;
        for (i = at; i + 1 < held_count; i++)
            sorted_vals[i] = sorted_vals[i + 1];
        held_count--;
    endfunction

    // Apply one request to the shadow table and return the result it must produce
    function automatic result_t apply_request(request_t req);
        result_t r;
        int      slot;
        int      i;
        r.status = ST_OK;
        slot = 0;
        case (req.action)
            ACT_INSERT:
            begin
                if (held_count >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // Equal values land in front of the existing ones
                    while (slot < held_count && sorted_vals[slot] < req.value)
                        slot++;
                    for (i = held_count; i > slot; i--)
                        sorted_vals[i] = sorted_vals[i - 1];
                    sorted_vals[slot] = req.value;
                    held_count++;
                end
            end
            ACT_DEL_POS:
            begin
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else if (int'(req.position) >= held_count)
                    r.status = ST_BADPOS;
                else
                begin
                    slot = int'(req.position);
                    drop_entry(slot);
                end
            end
            default:
            begin
                // Search and delete by key both act on the first equal entry
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    while (slot < held_count && sorted_vals[slot] != req.value)
                        slot++;
                    if (slot >= held_count)
                        r.status = ST_NOTFOUND;
                    else if (req.action == ACT_DEL_KEY)
                        drop_entry(slot);
                end
            end
        endcase
        if (r.status != ST_OK)
            slot = 0;
        r.index     = slot[INDEX_W-1:0];
        r.occupancy = held_count[OCCUPANCY_W-1:0];
        return r;
    endfunction

    function automatic void add_row(logic [ACTION_W-1:0] act, logic signed [VAL_W-1:0] val,
                                    logic [POS_W-1:0] pos, bit typed,
                                    logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] idx,
                                    logic [OCCUPANCY_W-1:0] occ);
        dir_row_t row;
        row.req.action   = act;
        row.req.value    = val;
        row.req.position = pos;
        row.typed        = typed;
        row.exp.status   = st;
        row.exp.index    = idx;
        row.exp.occupancy = occ;
        dir_rows.push_back(row);
    endfunction

    // Pick a value: in under half the cases a narrow band so keys collide, sometimes
    // the extremes, and as often as the band any 32-bit pattern
    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return $signed($urandom_range(16)) - 8;
        else if (r < 55)
        begin
            case ($urandom_range(3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    // Build a random request; mode 0 leans to inserts, 1 to removals, 2 mixes
    function automatic request_t random_request(int mode);
        request_t req;
        int       r;
        r = $urandom_range(99);
        case (mode)
            0: req.action = (r < 55) ? ACT_INSERT : (r < 65) ? ACT_DEL_POS :
                            (r < 85) ? ACT_SEARCH : ACT_DEL_KEY;
            1: req.action = (r < 15) ? ACT_INSERT : (r < 50) ? ACT_DEL_POS :
                            (r < 70) ? ACT_SEARCH : ACT_DEL_KEY;
            default: req.action = (r < 30) ? ACT_INSERT : (r < 50) ? ACT_DEL_POS :
                                  (r < 75) ? ACT_SEARCH : ACT_DEL_KEY;
        endcase
        req.value = pick_value();
        // Aim most key lookups at something actually held
        if ((req.action == ACT_SEARCH || req.action == ACT_DEL_KEY) && held_count > 0
            && $urandom_range(99) < 60)
            req.value = sorted_vals[$urandom_range(held_count - 1)];
        if (req.action == ACT_DEL_POS && held_count > 0 && $urandom_range(99) < 70)
            req.position = POS_W'($urandom_range(held_count - 1));
        else
            req.position = POS_W'($urandom_range(15));
        return req;
    endfunction

    // Offer one request beat, with random idle cycles ahead of it, and hold it
    // until the block takes it
    task automatic send_beat(request_t req, bit typed, result_t exp);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_BITS{1'b0}}, req.position, req.value, req.action};
        beat_typed    <= typed;
        beat_exp      <= exp;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Receiver back-pressure: re-rolled every cycle at the current stall rate
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Monitor: check result beats against the oldest expectation, then record
    // the expectation for a request beat taken at the same edge. The check goes
    // first since a result never belongs to a request accepted at that edge.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        result_t predicted;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status    = m_axis_tdata[2:0];
                got.index     = m_axis_tdata[6:3];
                got.occupancy = m_axis_tdata[11:7];
                results_checked++;
                if (got.status < 5)
                    status_seen[got.status]++;
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing expected: status %0d index %0d %s %0d",
                           got.status, got.index, "occupancy", got.occupancy);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.index != want.index)
                    begin
                        $error("index: expected %0d, got %0d", want.index, got.index);
                        error_count++;
                    end
                    if (got.occupancy != want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy,
                               got.occupancy);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                // Always advance the shadow table; a typed row overrides the
                // predicted result with the one written in the table
                predicted = apply_request({s_axis_tdata[1:0], s_axis_tdata[33:2],
                                           s_axis_tdata[37:34]});
                pending_results.push_back(beat_typed ? beat_exp : predicted);
            end
            // Watchdog: count cycles in which no beat moves on either side
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        int      phase;
        int      n;
        result_t none;
        none            = '0;
        rst_n           <= 1'b0;
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        beat_typed      <= 1'b0;
        beat_exp        <= '0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        error_count     = 0;
        requests_sent   = 0;
        results_checked = 0;
        stall_cycles    = 0;
        held_count      = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Directed rows: removals and search on the empty table, fill to the
        // brim with extremes and duplicates, refuse one more, then hit the
        // first entry, a position past the end, a missing key and held keys
        add_row(ACT_SEARCH,  0,       4'd0,  1'b1, ST_EMPTY,    4'd0, 5'd0);
        add_row(ACT_DEL_POS, 0,       4'd0,  1'b1, ST_EMPTY,    4'd0, 5'd0);
        add_row(ACT_DEL_KEY, 5,       4'd15, 1'b1, ST_EMPTY,    4'd0, 5'd0);
        add_row(ACT_INSERT,  VAL_MIN, 4'd15, 1'b1, ST_OK,       4'd0, 5'd1);
        add_row(ACT_INSERT,  VAL_MAX, 4'd10, 1'b1, ST_OK,       4'd1, 5'd2);
        add_row(ACT_INSERT,  0,       4'd5,  1'b1, ST_OK,       4'd1, 5'd3);
        add_row(ACT_INSERT,  0,       4'd0,  1'b1, ST_OK,       4'd1, 5'd4);
        add_row(ACT_INSERT,  -1,              4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  1,               4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  100,             4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  -100,            4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  32'sh4000_0000,  4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  32'shc000_0000,  4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  7,               4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  7,               4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  7,               4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  -7,              4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  12345,           4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  -12345,          4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_INSERT,  5,       4'd0,  1'b1, ST_FULL,     4'd0, 5'd16);
        add_row(ACT_SEARCH,  7,               4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_SEARCH,  99,      4'd3,  1'b1, ST_NOTFOUND, 4'd0, 5'd16);
        add_row(ACT_DEL_POS, 0,       4'd0,  1'b1, ST_OK,       4'd0, 5'd15);
        add_row(ACT_DEL_POS, 0,       4'd15, 1'b1, ST_BADPOS,   4'd0, 5'd15);
        add_row(ACT_DEL_KEY, 7,               4'd0, 1'b0, ST_OK, 4'd0, 5'd0);
        add_row(ACT_DEL_KEY, VAL_MAX,         4'd0, 1'b0, ST_OK, 4'd0, 5'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp);

        // Random part: four pressure phases, each cycling through fill, drain
        // and churn stretches so the table swings between full and empty
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 56; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 56; end
                default: begin sender_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                send_beat(random_request((n / MIX_BLOCK) % 3), 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;
        sink_stall_pct = 0;

        // Wait out the outstanding results, then keep the clock running so that
        // any stray beat can still show
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end

        $display("Sent %0d requests (%0d directed) and checked %0d results",
                 requests_sent, dir_rows.size(), results_checked);
        $display("Status mix over four pressure phases: ok %0d, empty %0d, %s %0d, %s %0d, %s %0d",
                 status_seen[0], status_seen[1], "bad position", status_seen[2],
                 "not found", status_seen[3], "full", status_seen[4]);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
